@@ sv/iopb_pkg.sv @@
// ----------------------------------------------------------------------------
// iopb_pkg
// Shared types, port codes and constants for the I/O port block.
// ----------------------------------------------------------------------------
package iopb_pkg;

	// Highest selectable memory bank
	localparam logic [3:0] MAX_BANK = 4'd7;

	// Access kinds
	localparam logic FUNC_READ  = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	// Port addresses
	localparam logic [7:0] PORT_SIO_STAT = 8'd0;
	localparam logic [7:0] PORT_SIO_DATA = 8'd1;
	localparam logic [7:0] PORT_BANK     = 8'd64;
	localparam logic [7:0] PORT_CTRL     = 8'd160;
	localparam logic [7:0] PORT_SW_A     = 8'd254;
	localparam logic [7:0] PORT_SW_B     = 8'd255;

	// Control port magic unlock byte
	localparam logic [7:0] CTRL_UNLOCK = 8'haa;

	// LED commands
	localparam logic [1:0] LED_NONE = 2'd0;
	localparam logic [1:0] LED_OFF  = 2'd1;
	localparam logic [1:0] LED_ON   = 2'd2;

	// CPU model change commands
	localparam logic [1:0] CPU_NONE = 2'd0;
	localparam logic [1:0] CPU_8080 = 2'd1;
	localparam logic [1:0] CPU_Z80  = 2'd2;

	// Reset value of the unmapped read byte
	localparam logic [7:0] UNMAPPED_RESET = 8'hff;

	// Stream widths
	localparam int TDATA_W = 32;

	// One port access
	typedef struct packed {
		logic       func;
		logic [7:0] port;
		logic [7:0] write_data;
		logic       rx_ready;
		logic [7:0] rx_byte;
	} item_t;

	// One access result
	typedef struct packed {
		logic [7:0] read_data;
		logic       rx_take;
		logic       tx_valid;
		logic [6:0] tx_byte;
		logic [1:0] led_state;
		logic       halt_request;
		logic       reset_request;
		logic [1:0] cpu_switch;
		logic       bank_write;
		logic [3:0] bank_select;
		logic       bank_error;
	} result_t;

	// Architectural state of the block
	typedef struct packed {
		logic [7:0] last_received;
		logic [7:0] switch_value;
		logic       control_locked;
		logic [3:0] current_bank;
	} state_t;

endpackage

@@ sv/iopb_decode.sv @@
// ----------------------------------------------------------------------------
// iopb_decode
// Port decode: forms the result and the next state for one access.
// ----------------------------------------------------------------------------
module iopb_decode
	import iopb_pkg::*;
(
	input  item_t      item,
	input  state_t     cur,
	input  logic [7:0] unmapped_read_value,
	output result_t    res,
	output state_t     nxt
);

	always_comb begin
		res = '0;
		nxt = cur;
		if (item.func == FUNC_READ) begin
			// Read side
			case (item.port)
				PORT_SIO_STAT: res.read_data = item.rx_ready ? 8'h00 : 8'h01;
				PORT_SIO_DATA: begin
					if (item.rx_ready) begin
						nxt.last_received = item.rx_byte;
						res.rx_take = 1'b1;
					end
					res.read_data = nxt.last_received;
				end
				PORT_BANK:     res.read_data = {MAX_BANK, cur.current_bank};
				PORT_CTRL:     res.read_data = cur.control_locked ? 8'hff : 8'h00;
				PORT_SW_A,
				PORT_SW_B:     res.read_data = cur.switch_value;
				default:       res.read_data = unmapped_read_value;
			endcase
		end else begin
			// Write side
			case (item.port)
				PORT_SIO_STAT: res.led_state = (item.write_data != 8'h00) ? LED_ON : LED_OFF;
				PORT_SIO_DATA: begin
					res.tx_valid = 1'b1;
					res.tx_byte  = item.write_data[6:0];
				end
				PORT_BANK: begin
					if (item.write_data > {4'h0, MAX_BANK}) begin
						res.bank_error = 1'b1;
					end else begin
						nxt.current_bank = item.write_data[3:0];
						res.bank_write   = 1'b1;
					end
				end
				PORT_CTRL: begin
					if (cur.control_locked) begin
						// Unlock only on the magic byte
						if (item.write_data == CTRL_UNLOCK) begin
							nxt.control_locked = 1'b0;
						end
					end else begin
						// Relock and take the highest-priority request
						nxt.control_locked = 1'b1;
						if (item.write_data[7]) begin
							res.halt_request = 1'b1;
						end else if (item.write_data[6]) begin
							res.reset_request = 1'b1;
						end else if (item.write_data[5]) begin
							res.cpu_switch = CPU_Z80;
						end else if (item.write_data[4]) begin
							res.cpu_switch = CPU_8080;
						end
					end
				end
				PORT_SW_A:     nxt.switch_value = item.write_data;
				default:       ;
			endcase
		end
		res.bank_select = nxt.current_bank;
	end

endmodule

@@ sv/io_port_block_with_locked_control.sv @@
// ----------------------------------------------------------------------------
// io_port_block_with_locked_control
// CPU I/O port block: serial, LED, bank, locked control and switch ports.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake         | payload
//  ----------+-----------+-------------------+------------------------------
//  s_*       | in        | s_tvalid/s_tready | one port access
//  m_*       | out       | m_tvalid/m_tready | one result per access
//  cfg_*     | in        | cfg_we            | unmapped read byte
//
//  One access per cycle unless m_tready stalls: an accepted transfer is held in
//  the input register, is decoded against the state registers and lands in the
//  result register, where the state is also updated.
//  Reset restores the lock, bank, switch and receive registers and empties
//  both stages. A stall on m_tready holds both stages; the input stage still
//  takes a transfer while the result register is full but its own is empty.
// ----------------------------------------------------------------------------
module io_port_block_with_locked_control
	import iopb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	// [7:0] port, [15:8] write_data, [16] rx_ready, [24:17] rx_byte
	input  logic [TDATA_W-1:0] s_tdata,
	// [0] func
	input  logic [0:0]         s_tuser,
	output logic               m_tvalid,
	input  logic               m_tready,
	// [7:0] read_data, [8] rx_take, [9] tx_valid, [16:10] tx_byte,
	// [18:17] led_state, [19] halt_request, [20] reset_request,
	// [22:21] cpu_switch, [23] bank_write, [27:24] bank_select, [28] bank_error
	output logic [TDATA_W-1:0] m_tdata,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata
);

	item_t      item_s1;
	logic       valid_s1;
	result_t    res_s2;
	logic       valid_s2;
	state_t     state_q;
	state_t     state_nxt;
	result_t    res_nxt;
	logic [7:0] unmapped_q;
	logic       adv_s2;
	logic       adv_s1;
	item_t      in_item;

	// Unpack the incoming transfer
	assign in_item.func       = s_tuser[0];
	assign in_item.port       = s_tdata[7:0];
	assign in_item.write_data = s_tdata[15:8];
	assign in_item.rx_ready   = s_tdata[16];
	assign in_item.rx_byte    = s_tdata[24:17];

	// Stage flow control
	assign adv_s2   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv_s2;
	assign adv_s1   = s_tvalid && s_tready;

	// Hold the unmapped read byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unmapped_q <= UNMAPPED_RESET;
		end else if (cfg_we) begin
			unmapped_q <= cfg_wdata;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			item_s1 <= in_item;
		end
	end

	iopb_decode u_decode (
		.item                (item_s1),
		.cur                 (state_q),
		.unmapped_read_value (unmapped_q),
		.res                 (res_nxt),
		.nxt                 (state_nxt)
	);

	// Advance the state as each access retires into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.last_received  <= 8'h00;
			state_q.switch_value   <= 8'h00;
			state_q.control_locked <= 1'b1;
			state_q.current_bank   <= 4'h0;
		end else if (adv_s2) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			res_s2 <= res_nxt;
		end
	end

	// Pack the outgoing transfer
	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'b000,
		res_s2.bank_error, res_s2.bank_select, res_s2.bank_write,
		res_s2.cpu_switch, res_s2.reset_request, res_s2.halt_request,
		res_s2.led_state, res_s2.tx_byte, res_s2.tx_valid,
		res_s2.rx_take, res_s2.read_data};

endmodule
